// ----- hdl/utf8sv_pkg.sv -----
// Package for the UTF-8 stream validator: request payload types, verdict
// codes, range class codes and the decoder state record.
// No dependencies.
package utf8sv_pkg;

  // Request payload of the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  // Request payload of the result channel.
  typedef struct packed {
    logic [1:0] verdict;
    logic       is_utf8;
  } out_req_t;

  // Verdict codes.
  localparam logic [1:0] VERDICT_VALID     = 2'd0;
  localparam logic [1:0] VERDICT_ASCII     = 2'd1;
  localparam logic [1:0] VERDICT_MALFORMED = 2'd2;
  localparam logic [1:0] VERDICT_TRUNCATED = 2'd3;

  // Range classes for the next continuation byte.
  localparam logic [2:0] RC_FULL = 3'd0;  // 80..BF
  localparam logic [2:0] RC_E0   = 3'd1;  // A0..BF
  localparam logic [2:0] RC_ED   = 3'd2;  // 80..9F
  localparam logic [2:0] RC_F0   = 3'd3;  // 90..BF
  localparam logic [2:0] RC_F4   = 3'd4;  // 80..8F

  // Byte constants used by the decoder.
  localparam logic [7:0] B_ASCII_END = 8'h80;
  localparam logic [7:0] B_LEAD2_LO  = 8'hC2;
  localparam logic [7:0] B_LEAD2_HI  = 8'hDF;
  localparam logic [7:0] B_LEAD3_LO  = 8'hE0;
  localparam logic [7:0] B_LEAD3_HI  = 8'hEF;
  localparam logic [7:0] B_LEAD3_ED  = 8'hED;
  localparam logic [7:0] B_LEAD4_LO  = 8'hF0;
  localparam logic [7:0] B_LEAD4_HI  = 8'hF4;
  localparam logic [7:0] B_LEAD_D4   = 8'hD4;
  localparam logic [7:0] B_PAIR_A5   = 8'hA5;
  localparam logic [7:0] B_CONT_LO   = 8'h80;
  localparam logic [7:0] B_CONT_HI   = 8'hBF;
  localparam logic [7:0] B_E0_LO     = 8'hA0;
  localparam logic [7:0] B_ED_HI     = 8'h9F;
  localparam logic [7:0] B_F0_LO     = 8'h90;
  localparam logic [7:0] B_F4_HI     = 8'h8F;
  localparam logic [1:0] CONT_TAG    = 2'b10;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    logic [1:0] bytes_pending;
    logic [2:0] range_class;
    logic       lead_was_d4;
    logic       only_ascii;
    logic       seen_error;
  } dec_state_t;

  localparam dec_state_t DEC_STATE_RESET = '{
    bytes_pending: 2'd0,
    range_class:   RC_FULL,
    lead_was_d4:   1'b0,
    only_ascii:    1'b1,
    seen_error:    1'b0
  };

endpackage

// ----- hdl/utf8_stream_validator_unit.sv -----
// Top level of the UTF-8 stream validator: input register, byte decoder,
// and a two-entry result queue.
// Depends on utf8sv_pkg.
//
// Usage: a string enters one byte per request on the in_ channel, with
// last_byte set on its final byte. Requests are taken when in_valid is high
// and in_stall is low. Each string produces exactly one result request on
// the out_ channel, carrying the verdict (valid non-ASCII, ASCII only,
// malformed, truncated) and is_utf8.
// A string's last byte passes through the input register, then through the
// decoder into the result queue, before its result can be taken; out_valid
// rises once the result is in the queue. Throughput: one byte per cycle,
// sustained while the receiver does not stall, including strings of a
// single byte each.
// The result queue holds two entries. When the receiver stalls, bytes that
// end no string keep flowing; in_stall rises only once both queue slots are
// spoken for by waiting results and the result still in the input register,
// and no result leaves the queue in that cycle.
// Reset (rst_n low, synchronous) empties the input register and the queue
// and returns the decoder to its start-of-string state.
module utf8_stream_validator_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  utf8sv_pkg::in_req_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output utf8sv_pkg::out_req_t out_data
);

  // Input register.
  logic                   s1_valid_r;
  utf8sv_pkg::in_req_t    s1_data_r;

  // Decoder state.
  utf8sv_pkg::dec_state_t st_r;
  utf8sv_pkg::dec_state_t st_nxt;
  utf8sv_pkg::dec_state_t upd;

  // Result queue: head entry, second entry and fill count.
  utf8sv_pkg::out_req_t   q0_r;
  utf8sv_pkg::out_req_t   q1_r;
  logic [1:0]             cnt_r;

  logic                   in_take;
  logic                   pop;
  logic                   push;
  logic [1:0]             pledged;
  logic [7:0]             b;
  logic [7:0]             lo;
  logic [7:0]             hi;
  utf8sv_pkg::out_req_t   res;

  // Handshake. Results already queued plus one waiting in the input register
  // may never exceed the queue depth.
  assign pop      = (cnt_r != 2'd0) && !out_stall;
  assign pledged  = cnt_r + {1'b0, s1_valid_r & s1_data_r.last_byte};
  assign in_stall = pledged[1] && !pop;
  assign in_take  = in_valid && !in_stall;
  assign push     = s1_valid_r && s1_data_r.last_byte;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q0_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
  end

  // Bounds of the next continuation byte for the current range class.
  always_comb begin
    unique case (st_r.range_class)
      utf8sv_pkg::RC_E0: begin
        lo = utf8sv_pkg::B_E0_LO;
        hi = utf8sv_pkg::B_CONT_HI;
      end
      utf8sv_pkg::RC_ED: begin
        lo = utf8sv_pkg::B_CONT_LO;
        hi = utf8sv_pkg::B_ED_HI;
      end
      utf8sv_pkg::RC_F0: begin
        lo = utf8sv_pkg::B_F0_LO;
        hi = utf8sv_pkg::B_CONT_HI;
      end
      utf8sv_pkg::RC_F4: begin
        lo = utf8sv_pkg::B_CONT_LO;
        hi = utf8sv_pkg::B_F4_HI;
      end
      default: begin
        lo = utf8sv_pkg::B_CONT_LO;
        hi = utf8sv_pkg::B_CONT_HI;
      end
    endcase
  end

  // Byte decoder: state after the byte in the input register.
  assign b = s1_data_r.data_byte;

  always_comb begin
    upd = st_r;
    if (!st_r.seen_error) begin
      if (b[7]) begin
        upd.only_ascii = 1'b0;
      end
      if (st_r.bytes_pending == 2'd0) begin
        // Lead byte expected.
        upd.lead_was_d4 = 1'b0;
        upd.range_class = utf8sv_pkg::RC_FULL;
        priority if (b < utf8sv_pkg::B_ASCII_END) begin
          upd.bytes_pending = 2'd0;
        end else if (b >= utf8sv_pkg::B_LEAD2_LO && b <= utf8sv_pkg::B_LEAD2_HI) begin
          upd.bytes_pending = 2'd1;
          upd.lead_was_d4   = (b == utf8sv_pkg::B_LEAD_D4);
        end else if (b >= utf8sv_pkg::B_LEAD3_LO && b <= utf8sv_pkg::B_LEAD3_HI) begin
          upd.bytes_pending = 2'd2;
          if (b == utf8sv_pkg::B_LEAD3_LO) begin
            upd.range_class = utf8sv_pkg::RC_E0;
          end else if (b == utf8sv_pkg::B_LEAD3_ED) begin
            upd.range_class = utf8sv_pkg::RC_ED;
          end
        end else if (b >= utf8sv_pkg::B_LEAD4_LO && b <= utf8sv_pkg::B_LEAD4_HI) begin
          upd.bytes_pending = 2'd3;
          if (b == utf8sv_pkg::B_LEAD4_LO) begin
            upd.range_class = utf8sv_pkg::RC_F0;
          end else if (b == utf8sv_pkg::B_LEAD4_HI) begin
            upd.range_class = utf8sv_pkg::RC_F4;
          end
        end else begin
          upd.seen_error = 1'b1;
        end
      end else begin
        // Continuation byte expected; a failure leaves the rest as it was.
        if ((b[7:6] != utf8sv_pkg::CONT_TAG) || (b < lo) || (b > hi) ||
            ((st_r.bytes_pending == 2'd1) && st_r.lead_was_d4 &&
             (b == utf8sv_pkg::B_PAIR_A5))) begin
          upd.seen_error = 1'b1;
        end else begin
          upd.range_class   = utf8sv_pkg::RC_FULL;
          upd.bytes_pending = st_r.bytes_pending - 2'd1;
        end
      end
    end
  end

  // Verdict for a string that ends with this byte.
  always_comb begin
    priority if (upd.seen_error) begin
      res.verdict = utf8sv_pkg::VERDICT_MALFORMED;
    end else if (upd.bytes_pending != 2'd0) begin
      res.verdict = utf8sv_pkg::VERDICT_TRUNCATED;
    end else if (upd.only_ascii) begin
      res.verdict = utf8sv_pkg::VERDICT_ASCII;
    end else begin
      res.verdict = utf8sv_pkg::VERDICT_VALID;
    end
    res.is_utf8 = (res.verdict == utf8sv_pkg::VERDICT_VALID);
  end

  // Next decoder state: the last byte of a string returns to the start.
  always_comb begin
    st_nxt = st_r;
    if (s1_valid_r) begin
      st_nxt = s1_data_r.last_byte ? utf8sv_pkg::DEC_STATE_RESET : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= utf8sv_pkg::DEC_STATE_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Result queue fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Result queue entries.
  always_ff @(posedge clk) begin
    unique case (cnt_r)
      2'd0: begin
        if (push) begin
          q0_r <= res;
        end
      end
      2'd1: begin
        if (push && pop) begin
          q0_r <= res;
        end else if (push) begin
          q1_r <= res;
        end
      end
      default: begin
        if (pop) begin
          q0_r <= q1_r;
        end
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // The queue never overfills.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count out of range");

  // A full queue is never pushed.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !push)
    else $error("push into full result queue");

  // is_utf8 follows the verdict on every delivered result.
  a_is_utf8: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_utf8 == (out_data.verdict == utf8sv_pkg::VERDICT_VALID)))
    else $error("is_utf8 disagrees with verdict");

  // The end of a string leaves the decoder at its start state.
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (st_r == utf8sv_pkg::DEC_STATE_RESET))
    else $error("decoder state not cleared after last byte");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the UTF-8 stream validator: directed strings, random strings and noise.
// Depends on utf8sv_pkg and utf8_stream_validator_unit.
`timescale 1ns / 1ps

module tb;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  utf8sv_pkg::in_req_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  utf8sv_pkg::out_req_t out_data;

  // Verdicts predicted for strings that are still in flight, oldest first.
  utf8sv_pkg::out_req_t   expected_verdicts[$];
  // Decoder state as the predictor sees it.
  utf8sv_pkg::dec_state_t decoder_model;
  // Bytes of the string that is about to be sent.
  logic [7:0]             str_bytes[$];

  int error_count = 0;
  int bytes_sent  = 0;
  bit idle_on     = 1'b1;
  int stall_left  = 0;

  utf8_stream_validator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Free-running clock with a 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the length of the run.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Add one byte at the end of the string under construction.
  task automatic add_str_byte(input logic [7:0] b);
    str_bytes = {str_bytes, b};
  endtask

  // Update the predicted decoder state with one accepted byte and queue a verdict
  // when the byte ends a string.
  task automatic predict_byte(input logic [7:0] b, input logic last);
    logic                 ok;
    logic [7:0]           lo;
    logic [7:0]           hi;
    utf8sv_pkg::out_req_t verdict_exp;
    ok = 1'b1;
    if (!decoder_model.seen_error) begin
      if (b[7]) decoder_model.only_ascii = 1'b0;
      if (decoder_model.bytes_pending == 2'd0) begin
        // A lead byte is expected.
        decoder_model.lead_was_d4 = 1'b0;
        decoder_model.range_class = utf8sv_pkg::RC_FULL;
        if (b < utf8sv_pkg::B_ASCII_END) begin
          decoder_model.bytes_pending = 2'd0;
        end else if (b >= utf8sv_pkg::B_LEAD2_LO && b <= utf8sv_pkg::B_LEAD2_HI) begin
          decoder_model.bytes_pending = 2'd1;
          decoder_model.lead_was_d4   = (b == utf8sv_pkg::B_LEAD_D4);
        end else if (b >= utf8sv_pkg::B_LEAD3_LO && b <= utf8sv_pkg::B_LEAD3_HI) begin
          decoder_model.bytes_pending = 2'd2;
          if (b == utf8sv_pkg::B_LEAD3_LO) decoder_model.range_class = utf8sv_pkg::RC_E0;
          else if (b == utf8sv_pkg::B_LEAD3_ED) decoder_model.range_class = utf8sv_pkg::RC_ED;
        end else if (b >= utf8sv_pkg::B_LEAD4_LO && b <= utf8sv_pkg::B_LEAD4_HI) begin
          decoder_model.bytes_pending = 2'd3;
          if (b == utf8sv_pkg::B_LEAD4_LO) decoder_model.range_class = utf8sv_pkg::RC_F0;
          else if (b == utf8sv_pkg::B_LEAD4_HI) decoder_model.range_class = utf8sv_pkg::RC_F4;
        end else begin
          ok = 1'b0;
        end
      end else begin
        // A continuation byte is expected; its range depends on the lead.
        case (decoder_model.range_class)
          utf8sv_pkg::RC_E0: begin
            lo = utf8sv_pkg::B_E0_LO;
            hi = utf8sv_pkg::B_CONT_HI;
          end
          utf8sv_pkg::RC_ED: begin
            lo = utf8sv_pkg::B_CONT_LO;
            hi = utf8sv_pkg::B_ED_HI;
          end
          utf8sv_pkg::RC_F0: begin
            lo = utf8sv_pkg::B_F0_LO;
            hi = utf8sv_pkg::B_CONT_HI;
          end
          utf8sv_pkg::RC_F4: begin
            lo = utf8sv_pkg::B_CONT_LO;
            hi = utf8sv_pkg::B_F4_HI;
          end
          default: begin
            lo = utf8sv_pkg::B_CONT_LO;
            hi = utf8sv_pkg::B_CONT_HI;
          end
        endcase
        ok = (b[7:6] == utf8sv_pkg::CONT_TAG) && (b >= lo) && (b <= hi) &&
             !(decoder_model.bytes_pending == 2'd1 && decoder_model.lead_was_d4 &&
               b == utf8sv_pkg::B_PAIR_A5);
        if (ok) begin
          decoder_model.range_class   = utf8sv_pkg::RC_FULL;
          decoder_model.bytes_pending = decoder_model.bytes_pending - 2'd1;
        end
      end
      if (!ok) decoder_model.seen_error = 1'b1;
    end
    if (last) begin
      if (decoder_model.seen_error) begin
        verdict_exp.verdict = utf8sv_pkg::VERDICT_MALFORMED;
      end else if (decoder_model.bytes_pending != 2'd0) begin
        verdict_exp.verdict = utf8sv_pkg::VERDICT_TRUNCATED;
      end else if (decoder_model.only_ascii) begin
        verdict_exp.verdict = utf8sv_pkg::VERDICT_ASCII;
      end else begin
        verdict_exp.verdict = utf8sv_pkg::VERDICT_VALID;
      end
      verdict_exp.is_utf8 = (verdict_exp.verdict == utf8sv_pkg::VERDICT_VALID);
      expected_verdicts = {expected_verdicts, verdict_exp};
      decoder_model = utf8sv_pkg::DEC_STATE_RESET;
    end
  endtask

  // Send one byte request and wait until it is accepted. Valid stays high on return
  // so that a following byte can go out on the next cycle.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.data_byte <= b;
    in_data.last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  // Send the bytes held in str_bytes as one string.
  task automatic send_string();
    for (int i = 0; i < str_bytes.size(); i++) begin
      send_byte(str_bytes[i], i == str_bytes.size() - 1);
    end
  endtask

  // Pick a continuation byte inside the range of the given class.
  function automatic logic [7:0] pick_cont(input logic [2:0] cls);
    case (cls)
      utf8sv_pkg::RC_E0:
        return 8'($urandom_range(utf8sv_pkg::B_CONT_HI, utf8sv_pkg::B_E0_LO));
      utf8sv_pkg::RC_ED:
        return 8'($urandom_range(utf8sv_pkg::B_ED_HI, utf8sv_pkg::B_CONT_LO));
      utf8sv_pkg::RC_F0:
        return 8'($urandom_range(utf8sv_pkg::B_CONT_HI, utf8sv_pkg::B_F0_LO));
      utf8sv_pkg::RC_F4:
        return 8'($urandom_range(utf8sv_pkg::B_F4_HI, utf8sv_pkg::B_CONT_LO));
      default:
        return 8'($urandom_range(utf8sv_pkg::B_CONT_HI, utf8sv_pkg::B_CONT_LO));
    endcase
  endfunction

  // Append one character of len bytes, keeping only keep of its continuation bytes.
  task automatic append_char(input int len, input int keep);
    logic [7:0] lead;
    logic [2:0] cls;
    cls = utf8sv_pkg::RC_FULL;
    case (len)
      1: lead = 8'($urandom_range(8'h7F, 8'h00));
      2: lead = 8'($urandom_range(utf8sv_pkg::B_LEAD2_HI, utf8sv_pkg::B_LEAD2_LO));
      3: begin
        lead = 8'($urandom_range(utf8sv_pkg::B_LEAD3_HI, utf8sv_pkg::B_LEAD3_LO));
        if (lead == utf8sv_pkg::B_LEAD3_LO) cls = utf8sv_pkg::RC_E0;
        else if (lead == utf8sv_pkg::B_LEAD3_ED) cls = utf8sv_pkg::RC_ED;
      end
      default: begin
        lead = 8'($urandom_range(utf8sv_pkg::B_LEAD4_HI, utf8sv_pkg::B_LEAD4_LO));
        if (lead == utf8sv_pkg::B_LEAD4_LO) cls = utf8sv_pkg::RC_F0;
        else if (lead == utf8sv_pkg::B_LEAD4_HI) cls = utf8sv_pkg::RC_F4;
      end
    endcase
    add_str_byte(lead);
    for (int i = 0; i < keep; i++) begin
      add_str_byte(pick_cont(i == 0 ? cls : utf8sv_pkg::RC_FULL));
    end
  endtask

  // Build a random string: mostly well formed, some broken, truncated or ASCII only.
  task automatic build_random_string();
    int shape;
    int chars;
    int len;
    int pos;
    str_bytes.delete();
    shape = $urandom_range(0, 9);
    chars = $urandom_range(1, 5);
    for (int c = 0; c < chars; c++) begin
      len = (shape == 8) ? 1 : $urandom_range(1, 4);
      append_char(len, len - 1);
    end
    if (shape == 6) begin
      // Overwrite one byte with anything at all.
      pos = $urandom_range(0, str_bytes.size() - 1);
      str_bytes[pos] = 8'($urandom_range(0, 255));
    end else if (shape == 7) begin
      // End the string inside a multibyte character.
      len = $urandom_range(2, 4);
      append_char(len, $urandom_range(0, len - 2));
    end else if (shape == 9) begin
      // Replace a continuation slot of the final character with a wrong byte.
      len = $urandom_range(2, 4);
      append_char(len, $urandom_range(0, len - 2));
      add_str_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 8'h7F))
                                        : 8'($urandom_range(8'hC0, 8'hFF)));
    end
  endtask

  // Results are checked against the oldest prediction at each accepted request.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual verdict %0d is_utf8 %0d",
                 $time, out_data.verdict, out_data.is_utf8);
        error_count++;
      end else begin
        if (out_data.verdict !== expected_verdicts[0].verdict) begin
          $display("%0t: verdict mismatch, expected %0d, actual %0d",
                   $time, expected_verdicts[0].verdict, out_data.verdict);
          error_count++;
        end
        if (out_data.is_utf8 !== expected_verdicts[0].is_utf8) begin
          $display("%0t: is_utf8 mismatch, expected %0d, actual %0d",
                   $time, expected_verdicts[0].is_utf8, out_data.is_utf8);
          error_count++;
        end
        void'(expected_verdicts.pop_front());
      end
    end
  end

  // The receiver stalls in random bursts while idling is enabled.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 11);
      end
    end
  end

  task automatic test_ascii_bounds();
    str_bytes = '{8'h00, 8'h7F};
    send_string();
  endtask

  task automatic test_multibyte_valid();
    str_bytes = '{8'hC2, 8'hBF};
    send_string();
    str_bytes = '{8'hF0, 8'h90, 8'h80, 8'hBF};
    send_string();
  endtask

  // Continuations outside their lead's range, and a non-continuation after a lead.
  // The first string also checks that bytes after a failure are ignored.
  task automatic test_continuation_ranges();
    str_bytes = '{8'hE0, 8'h9F, 8'h80};
    send_string();
    str_bytes = '{8'hED, 8'hA0};
    send_string();
    str_bytes = '{8'hF4, 8'h90};
    send_string();
    str_bytes = '{8'hDF, 8'h41};
    send_string();
  endtask

  task automatic test_d4_a5_pair();
    str_bytes = '{8'hD4, 8'hA5};
    send_string();
  endtask

  // Overlong lead, lead beyond F4, and a stray continuation.
  task automatic test_invalid_leads();
    str_bytes = '{8'hC1};
    send_string();
    str_bytes = '{8'hFF};
    send_string();
    str_bytes = '{8'h80};
    send_string();
  endtask

  task automatic test_truncated();
    str_bytes = '{8'hE1, 8'h80};
    send_string();
  endtask

  task automatic test_random_strings(input int byte_goal);
    int stop_at;
    stop_at = bytes_sent + byte_goal;
    while (bytes_sent < stop_at) begin
      build_random_string();
      send_string();
    end
  endtask

  // Unstructured bytes of any value, in strings of random length.
  task automatic test_random_noise(input int byte_goal);
    int stop_at;
    int len;
    stop_at = bytes_sent + byte_goal;
    while (bytes_sent < stop_at) begin
      str_bytes.delete();
      len = $urandom_range(1, 8);
      repeat (len) add_str_byte(8'($urandom_range(0, 255)));
      send_string();
    end
  endtask

  // Back-to-back traffic with neither side idling.
  task automatic test_streaming(input int byte_goal);
    idle_on = 1'b0;
    test_random_strings(byte_goal);
  endtask

  // Reset, then the tests in turn, then drain and report.
  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    decoder_model = utf8sv_pkg::DEC_STATE_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ascii_bounds();
    test_multibyte_valid();
    test_continuation_ranges();
    test_d4_a5_pair();
    test_invalid_leads();
    test_truncated();
    test_random_strings(1150);
    test_random_noise(250);
    test_streaming(130);

    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/utf8sv_pkg.sv
hdl/utf8_stream_validator_unit.sv
tb/sv/tb.sv
